FILE: rtl/zzvd_pkg.sv
// ----------------------------------------------------------------------------
// zzvd_pkg
// Types and constants shared by the zigzag varint decoder modules.
// ----------------------------------------------------------------------------
package zzvd_pkg;

  localparam logic [7:0] GROUP_MASK       = 8'h7F;
  localparam logic [7:0] MORE_BIT         = 8'h80;
  localparam logic [4:0] MAX_BYTES_NARROW = 5'd5;
  localparam logic [4:0] MAX_BYTES_WIDE   = 5'd10;
  localparam logic [6:0] GROUP_BITS       = 7'd7;
  localparam logic [6:0] ACC_WIDTH        = 7'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       zigzag;
    logic       wide;
  } zzvd_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               overlong;
  } zzvd_out_t;

  // one byte's outcome, from the accumulator to the result stage
  typedef struct packed {
    logic        emit;
    logic        overlong;
    logic        zigzag;
    logic        wide;
    logic [63:0] raw;
  } zzvd_step_t;

endpackage

FILE: rtl/zzvd_acc.sv
// ----------------------------------------------------------------------------
// zzvd_acc
// Seven-bit group accumulator and byte counter; decides where a value ends.
// ----------------------------------------------------------------------------
module zzvd_acc import zzvd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  zzvd_in_t   item,
  input  logic       fire,
  output zzvd_step_t step
);

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [6:0]  shamt;
  logic [63:0] group;
  logic [63:0] acc_cur;
  logic [4:0]  taken;
  logic [4:0]  limit;
  logic        more;
  logic        emit;

  assign shamt   = {3'b000, cnt_r} * GROUP_BITS;
  assign group   = {56'd0, item.in_byte & GROUP_MASK};
  assign acc_cur = (shamt < ACC_WIDTH) ? (acc_r | (group << shamt[5:0])) : acc_r;
  assign taken   = {1'b0, cnt_r} + 5'd1;
  assign limit   = item.wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
  assign more    = (item.in_byte & MORE_BIT) != 8'd0;
  assign emit    = !more || (taken >= limit);

  assign step.emit     = emit;
  assign step.overlong = more;
  assign step.zigzag   = item.zigzag;
  assign step.wide     = item.wide;
  assign step.raw      = acc_cur;

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (emit) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_cur;
        cnt_nxt = taken[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/zzvd_fin.sv
// ----------------------------------------------------------------------------
// zzvd_fin
// Zigzag and width finishing of a completed value, held in the result register.
// ----------------------------------------------------------------------------
module zzvd_fin import zzvd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  zzvd_step_t step,
  input  logic       load,
  output logic       out_valid,
  input  logic       out_ready,
  output zzvd_out_t  out_data
);

  logic        out_valid_r, out_valid_nxt;
  zzvd_out_t   out_data_r, out_data_nxt;
  logic [63:0] val64;
  logic [31:0] raw32;
  logic [31:0] val32;
  logic [63:0] value;

  always_comb begin
    raw32 = step.raw[31:0];
    val64 = step.zigzag ? ({1'b0, step.raw[63:1]} ^ {64{step.raw[0]}}) : step.raw;
    val32 = step.zigzag ? ({1'b0, raw32[31:1]} ^ {32{raw32[0]}}) : raw32;
    value = step.wide ? val64 : {{32{val32[31]}}, val32};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.value    = value;
      out_data_nxt.overlong = step.overlong;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/zigzag_varint_decoder.sv
// ----------------------------------------------------------------------------
// zigzag_varint_decoder
// LEB128 varint stream decoder with optional zigzag and 32/64-bit modes.
// ----------------------------------------------------------------------------
// One byte beat is taken every cycle. A byte passes the input register, then
// the group accumulator and finishing logic into the result register. The
// only stall comes from the result register: a byte that ends a value waits
// while an earlier result is still held; continuation bytes never wait. A
// value ends on a byte with bit 7 clear, or after 5 bytes (32-bit) or 10
// bytes (64-bit), then flagged overlong.
// ----------------------------------------------------------------------------
module zigzag_varint_decoder import zzvd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  zzvd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output zzvd_out_t out_data
);

  logic       in_v_r, in_v_nxt;
  zzvd_in_t   in_r, in_nxt;
  zzvd_step_t step;
  logic       consume;
  logic       res_load;

  assign consume  = in_v_r && (!step.emit || !out_valid || out_ready);
  assign res_load = consume && step.emit;
  assign in_ready = !in_v_r || consume;

  always_comb begin
    in_v_nxt = in_v_r;
    in_nxt   = in_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
      in_nxt   = in_data;
    end else if (consume) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  zzvd_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_r),
    .fire  (consume),
    .step  (step)
  );

  zzvd_fin u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .load      (res_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // held byte is not lost while the result register is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !consume |=> in_v_r && $stable(in_r))
    else $error("input register changed while stalled");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_load && out_valid && !out_ready))
    else $error("result register overwritten");

  // a new result only follows a byte that ended a value
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_load))
    else $error("result without ending byte");

endmodule
